/* rtl/core/rpvg_pkg.sv */
// Shared types, constants and tables for the polygon vertex generator.
`timescale 1ns / 1ps
package rpvg_pkg;
	localparam int MAX_SIDES = 64;
	localparam int MIN_SIDES = 3;
	localparam int COORD_W = 24;
	localparam int RADIUS_W = 23;
	localparam int ANGLE_W = 16;
	localparam int SIDES_W = 7;
	localparam int INDEX_W = 6;
	localparam int CORDIC_STEPS = 30;
	localparam int CX_W = 34;
	localparam int CZ_W = 33;
	localparam int PROD_W = 56;
	localparam int SUM_W = 28;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [ANGLE_W-1:0] angle;
		logic last;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RADIUS_W-1:0] r;
	} job_t;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic signed [COORD_W-1:0] vx;
		logic signed [COORD_W-1:0] vy;
		logic last;
	} result_t;

	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051D;
			5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2E;
			5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B; 5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028; 5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002; 5'd29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return v;
	endfunction
endpackage

/* rtl/core/rpvg_front.sv */
// Request intake: side clamp, step division and vertex angle sequencing into a job queue.
`timescale 1ns / 1ps
module rpvg_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [rpvg_pkg::COORD_W-1:0] center_x,
	input  logic signed [rpvg_pkg::COORD_W-1:0] center_y,
	input  logic [rpvg_pkg::RADIUS_W-1:0] radius,
	input  logic [rpvg_pkg::ANGLE_W-1:0] yaw_angle,
	input  logic [rpvg_pkg::SIDES_W-1:0] sides,
	output logic job_valid,
	output rpvg_pkg::job_t job,
	input  logic job_take
);
	typedef enum logic [1:0] {F_IDLE, F_DIV, F_GEN} fstate_t;
	fstate_t state_q;
	logic signed [rpvg_pkg::COORD_W-1:0] cx_q, cy_q;
	logic [rpvg_pkg::RADIUS_W-1:0] r_q;
	logic [rpvg_pkg::ANGLE_W-1:0] yaw_q, qacc_q, qstep_q;
	logic [rpvg_pkg::SIDES_W-1:0] n_q, rem_q, racc_q, rstep_q;
	logic [rpvg_pkg::ANGLE_W:0] quo_q;
	logic [4:0] cnt_q;
	logic [rpvg_pkg::INDEX_W-1:0] idx_q;
	rpvg_pkg::job_t qmem_q [2];
	logic wp_q, rp_q;
	logic [1:0] qcnt_q;

	logic [rpvg_pkg::SIDES_W-1:0] n_clamp;
	logic [rpvg_pkg::SIDES_W:0] rem_sh, rsum;
	logic qbit, q_push;
	logic [rpvg_pkg::ANGLE_W:0] quo_next;
	logic [rpvg_pkg::SIDES_W-1:0] rem_next;
	rpvg_pkg::job_t new_job;

	always_comb begin
		if (sides < rpvg_pkg::SIDES_W'(rpvg_pkg::MIN_SIDES))
			n_clamp = rpvg_pkg::SIDES_W'(rpvg_pkg::MIN_SIDES);
		else if (sides > rpvg_pkg::SIDES_W'(rpvg_pkg::MAX_SIDES))
			n_clamp = rpvg_pkg::SIDES_W'(rpvg_pkg::MAX_SIDES);
		else
			n_clamp = sides;
		rem_sh = {rem_q, (cnt_q == 5'd0)};
		qbit = rem_sh >= {1'b0, n_q};
		rem_next = qbit ? rpvg_pkg::SIDES_W'(rem_sh - {1'b0, n_q})
			: rem_sh[rpvg_pkg::SIDES_W-1:0];
		quo_next = {quo_q[rpvg_pkg::ANGLE_W-1:0], qbit};
		rsum = {1'b0, racc_q} + {1'b0, rstep_q};
		new_job.idx = idx_q;
		new_job.angle = yaw_q + qacc_q;
		new_job.last = ({1'b0, idx_q} == n_q - 7'd1);
		new_job.cx = cx_q;
		new_job.cy = cy_q;
		new_job.r = r_q;
		q_push = (state_q == F_GEN) && (qcnt_q != 2'd2);
	end

	assign full = (state_q != F_IDLE);
	assign job_valid = (qcnt_q != 2'd0);
	assign job = qmem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			qcnt_q <= 2'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						cx_q <= center_x;
						cy_q <= center_y;
						r_q <= radius;
						yaw_q <= yaw_angle;
						n_q <= n_clamp;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 5'd0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q <= rem_next;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(rpvg_pkg::ANGLE_W)) begin
						qstep_q <= quo_next[rpvg_pkg::ANGLE_W-1:0];
						rstep_q <= rem_next;
						qacc_q <= '0;
						racc_q <= n_q >> 1;
						idx_q <= '0;
						state_q <= F_GEN;
					end
				end
				F_GEN: begin
					if (q_push) begin
						idx_q <= idx_q + 6'd1;
						if (rsum >= {1'b0, n_q}) begin
							racc_q <= rpvg_pkg::SIDES_W'(rsum - {1'b0, n_q});
							qacc_q <= qacc_q + qstep_q + 16'd1;
						end else begin
							racc_q <= rsum[rpvg_pkg::SIDES_W-1:0];
							qacc_q <= qacc_q + qstep_q;
						end
						if (new_job.last)
							state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
			if (q_push) begin
				qmem_q[wp_q] <= new_job;
				wp_q <= ~wp_q;
			end
			if (job_take && job_valid)
				rp_q <= ~rp_q;
			qcnt_q <= qcnt_q + {1'b0, q_push} - {1'b0, job_take && job_valid};
		end
	end
endmodule

/* rtl/core/rpvg_back.sv */
// Vertex engine: iterative CORDIC, radius scaling, translation with saturation, result queue.
`timescale 1ns / 1ps
module rpvg_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  rpvg_pkg::job_t job,
	output logic job_take,
	output logic empty,
	input  logic pop,
	output rpvg_pkg::result_t res
);
	typedef enum logic [2:0] {B_IDLE, B_ROT, B_MULX, B_MULY, B_OUT} bstate_t;
	bstate_t state_q;
	rpvg_pkg::job_t job_q;
	logic signed [rpvg_pkg::CX_W-1:0] x_q, y_q;
	logic signed [rpvg_pkg::CZ_W-1:0] z_q;
	logic [4:0] cnt_q;
	logic signed [rpvg_pkg::PROD_W-1:0] prod_q;
	logic signed [rpvg_pkg::COORD_W-1:0] vx_q;
	rpvg_pkg::result_t rmem_q [2];
	logic wp_q, rp_q;
	logic [1:0] rcnt_q;

	logic [31:0] a32;
	logic flip, r_push;
	logic signed [rpvg_pkg::CX_W-1:0] dx, dy;
	logic signed [rpvg_pkg::CZ_W-1:0] at;
	logic signed [rpvg_pkg::PROD_W-1:0] mul_in, rnd;
	logic signed [rpvg_pkg::COORD_W:0] r_s;
	logic signed [31:0] cs;
	logic signed [rpvg_pkg::SUM_W-1:0] sum;
	logic signed [rpvg_pkg::COORD_W-1:0] cen, fin;
	rpvg_pkg::result_t new_res;

	always_comb begin
		a32 = {job.angle, 16'd0};
		flip = a32[31] ^ a32[30];
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		at = $signed({1'b0, rpvg_pkg::atan_turns(cnt_q)});
		r_s = $signed({2'b00, job_q.r});
		cs = (state_q == B_MULX) ? x_q[31:0] : y_q[31:0];
		mul_in = r_s * cs;
		cen = (state_q == B_OUT) ? job_q.cy : job_q.cx;
		rnd = (prod_q + 56'sd536870912) >>> 30;
		sum = $signed(rnd[rpvg_pkg::SUM_W-1:0]) + rpvg_pkg::SUM_W'(cen);
		if (sum > 28'sd8388607)
			fin = 24'sh7FFFFF;
		else if (sum < -28'sd8388608)
			fin = 24'sh800000;
		else
			fin = sum[rpvg_pkg::COORD_W-1:0];
		new_res.idx = job_q.idx;
		new_res.vx = vx_q;
		new_res.vy = fin;
		new_res.last = job_q.last;
		r_push = (state_q == B_OUT) && (rcnt_q != 2'd2);
	end

	assign job_take = (state_q == B_IDLE) && job_valid;
	assign empty = (rcnt_q == 2'd0);
	assign res = rmem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			rcnt_q <= 2'd0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						x_q <= flip ? -rpvg_pkg::CORDIC_GAIN : rpvg_pkg::CORDIC_GAIN;
						y_q <= '0;
						z_q <= $signed({a32[31] ^ flip, a32[31] ^ flip, a32[30:0]});
						cnt_q <= 5'd0;
						state_q <= B_ROT;
					end
				end
				B_ROT: begin
					if (!z_q[rpvg_pkg::CZ_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(rpvg_pkg::CORDIC_STEPS - 1))
						state_q <= B_MULX;
				end
				B_MULX: begin
					prod_q <= mul_in;
					state_q <= B_MULY;
				end
				B_MULY: begin
					vx_q <= fin;
					prod_q <= mul_in;
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (r_push)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (r_push) begin
				rmem_q[wp_q] <= new_res;
				wp_q <= ~wp_q;
			end
			if (pop && !empty)
				rp_q <= ~rp_q;
			rcnt_q <= rcnt_q + {1'b0, r_push} - {1'b0, pop && !empty};
		end
	end
endmodule

/* rtl/core/regular_polygon_vertex_generator_unit.sv */
// Regular polygon vertex generator top level.
// One request (center, radius, yaw, sides) yields one vertex per side, sides clamped to 3..64,
// in index order with last set on the final one. The front takes a request, runs a 17-step
// divider for the angle step and then queues one vertex job per cycle while its job queue has
// room; the back takes one vertex job at a time (job load, 30 CORDIC iterations, x and y
// multiply steps, output once the result queue has room). full stays high while the front
// sequences a request; results wait in a two-entry output queue.
`timescale 1ns / 1ps
module regular_polygon_vertex_generator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [rpvg_pkg::COORD_W-1:0] center_x,
	input  logic signed [rpvg_pkg::COORD_W-1:0] center_y,
	input  logic [rpvg_pkg::RADIUS_W-1:0] radius,
	input  logic [rpvg_pkg::ANGLE_W-1:0] yaw_angle,
	input  logic [rpvg_pkg::SIDES_W-1:0] sides,
	output logic empty,
	input  logic pop,
	output logic [rpvg_pkg::INDEX_W-1:0] vertex_index,
	output logic signed [rpvg_pkg::COORD_W-1:0] vertex_x,
	output logic signed [rpvg_pkg::COORD_W-1:0] vertex_y,
	output logic last
);
	logic job_valid, job_take;
	rpvg_pkg::job_t job;
	rpvg_pkg::result_t res;

	rpvg_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.center_x(center_x), .center_y(center_y), .radius(radius),
		.yaw_angle(yaw_angle), .sides(sides),
		.job_valid(job_valid), .job(job), .job_take(job_take)
	);

	rpvg_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .empty(empty), .pop(pop), .res(res)
	);

	assign vertex_index = res.idx;
	assign vertex_x = res.vx;
	assign vertex_y = res.vy;
	assign last = res.last;
endmodule

/* test/rpvg_vertex_checker.sv */
// Vertex predictor and result checker for the polygon vertex generator testbench.
`timescale 1ns / 1ps
module rpvg_vertex_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic full,
	input  logic signed [rpvg_pkg::COORD_W-1:0] center_x,
	input  logic signed [rpvg_pkg::COORD_W-1:0] center_y,
	input  logic [rpvg_pkg::RADIUS_W-1:0] radius,
	input  logic [rpvg_pkg::ANGLE_W-1:0] yaw_angle,
	input  logic [rpvg_pkg::SIDES_W-1:0] sides,
	input  logic empty,
	input  logic pop,
	input  logic [rpvg_pkg::INDEX_W-1:0] vertex_index,
	input  logic signed [rpvg_pkg::COORD_W-1:0] vertex_x,
	input  logic signed [rpvg_pkg::COORD_W-1:0] vertex_y,
	input  logic last,
	output int errors,
	output int pending
);
	import rpvg_pkg::*;

	localparam longint COORD_HI = (64'sd1 <<< (COORD_W - 1)) - 1;
	localparam longint COORD_LO = -COORD_HI - 1;

	result_t vertex_q[$];

	assign pending = vertex_q.size();

	function automatic void unit_vector(input logic [31:0] turn, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		logic [31:0] ang;
		ang = turn;
		x = longint'(CORDIC_GAIN);
		y = 0;
		if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
			ang = ang ^ 32'h80000000;
			x = -x;
		end
		z = longint'(signed'(ang));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(atan_turns(i[4:0]));
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(atan_turns(i[4:0]));
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic logic signed [COORD_W-1:0] offset_coord(input longint ctr,
			input longint r, input longint u);
		longint v;
		v = ctr + ((r * u + (64'sd1 <<< 29)) >>> 30);
		if (v > COORD_HI) v = COORD_HI;
		if (v < COORD_LO) v = COORD_LO;
		return v[COORD_W-1:0];
	endfunction

	task automatic predict_polygon();
		longint n, stp, c, s;
		logic [ANGLE_W-1:0] a;
		result_t e;
		n = longint'(sides);
		if (n < MIN_SIDES) n = MIN_SIDES;
		if (n > MAX_SIDES) n = MAX_SIDES;
		for (longint i = 0; i < n; i++) begin
			stp = ((i << ANGLE_W) + n / 2) / n;
			a = yaw_angle + stp[ANGLE_W-1:0];
			unit_vector({a, {(32 - ANGLE_W){1'b0}}}, c, s);
			e.idx = i[INDEX_W-1:0];
			e.vx = offset_coord(longint'(center_x), longint'(radius), c);
			e.vy = offset_coord(longint'(center_y), longint'(radius), s);
			e.last = (i + 1 == n);
			vertex_q.push_back(e);
		end
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (push && !full) predict_polygon();
			if (pop && !empty) begin
				if (vertex_q.size() == 0) begin
					$display("%0t: unexpected vertex idx=%0d x=%0d y=%0d last=%0b", $time,
						vertex_index, vertex_x, vertex_y, last);
					errors++;
				end else begin
					e = vertex_q.pop_front();
					if (vertex_index !== e.idx) begin
						$display("%0t: vertex_index expected %0d actual %0d", $time, e.idx,
							vertex_index);
						errors++;
					end
					if (vertex_x !== e.vx) begin
						$display("%0t: vertex_x expected %0d actual %0d", $time, e.vx, vertex_x);
						errors++;
					end
					if (vertex_y !== e.vy) begin
						$display("%0t: vertex_y expected %0d actual %0d", $time, e.vy, vertex_y);
						errors++;
					end
					if (last !== e.last) begin
						$display("%0t: last expected %0b actual %0b", $time, e.last, last);
						errors++;
					end
				end
			end
		end
	end
endmodule

/* test/regular_polygon_vertex_generator_unit_tb.sv */
// Stimulus and verdict for the polygon vertex generator testbench.
`timescale 1ns / 1ps
module regular_polygon_vertex_generator_unit_tb;
	import rpvg_pkg::*;

	logic clk, arst_n, push, full, empty, pop, last;
	logic signed [COORD_W-1:0] center_x, center_y, vertex_x, vertex_y;
	logic [RADIUS_W-1:0] radius;
	logic [ANGLE_W-1:0] yaw_angle;
	logic [SIDES_W-1:0] sides;
	logic [INDEX_W-1:0] vertex_index;
	logic quiet;
	int errors, pending;

	localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W - 1){1'b1}}};
	localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W - 1){1'b0}}};
	localparam logic [RADIUS_W-1:0] RMAX = '1;

	regular_polygon_vertex_generator_unit uut (.*);

	rpvg_vertex_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("regular_polygon_vertex_generator_unit_tb: errors");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
		end else begin
			pop <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
		end
	end

	task automatic send_polygon(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [RADIUS_W-1:0] r, input logic [ANGLE_W-1:0] yaw,
			input logic [SIDES_W-1:0] n);
		while (!quiet && $urandom_range(99) < 34) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		center_x <= x;
		center_y <= y;
		radius <= r;
		yaw_angle <= yaw;
		sides <= n;
		do @(posedge clk); while (full);
	endtask

	task automatic send_random();
		logic [COORD_W-1:0] x, y;
		logic [RADIUS_W-1:0] r;
		logic [SIDES_W-1:0] n;
		x = COORD_W'($urandom);
		y = COORD_W'($urandom);
		r = ($urandom_range(3) == 0) ? RADIUS_W'($urandom) : RADIUS_W'($urandom_range(65535));
		if ($urandom_range(3) == 0) begin
			x = $urandom_range(1) ? CMAX - COORD_W'($urandom_range(255))
				: CMIN + COORD_W'($urandom_range(255));
			r = RMAX - RADIUS_W'($urandom_range(4095));
		end
		case ($urandom_range(19))
			0: n = SIDES_W'($urandom);
			1: n = SIDES_W'($urandom_range(64, 127));
			2: n = SIDES_W'(MAX_SIDES);
			default: n = SIDES_W'($urandom_range(12));
		endcase
		send_polygon(x, y, r, ANGLE_W'($urandom), n);
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		quiet = 0;
		center_x = 0;
		center_y = 0;
		radius = 0;
		yaw_angle = 0;
		sides = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_polygon(0, 0, 0, 0, 0);
		send_polygon(0, 0, 256, 0, 1);
		send_polygon(100, COORD_W'(-100), 1000, 16'hFFFF, 2);
		send_polygon(0, 0, 25600, 0, 3);
		send_polygon(0, 0, 25600, 16'h4000, 4);
		send_polygon(CMAX, CMAX, RMAX, 0, 4);
		send_polygon(CMIN, CMIN, RMAX, 16'h2000, 4);
		send_polygon(CMAX, CMIN, RMAX, 16'h8000, 6);
		send_polygon(CMIN, CMAX, RMAX, 16'hC000, 5);
		send_polygon(COORD_W'(-5), 7, 12345, 16'h1234, 63);
		send_polygon(CMAX, CMIN, RMAX, 16'hFFFF, 64);
		send_polygon(1, 1, 3, 16'h8001, 65);
		send_polygon(COORD_W'(-1), COORD_W'(-1), RMAX, 16'h7FFF, 127);
		send_polygon(0, 0, 1, 0, 7);
		push <= 0;
		wait (pending == 0);
		@(posedge clk);
		for (int i = 0; i < 440; i++) begin
			quiet = (i >= 150 && i < 220);
			send_random();
		end
		push <= 0;
		quiet = 0;
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("regular_polygon_vertex_generator_unit_tb: clean");
		else
			$display("regular_polygon_vertex_generator_unit_tb: errors");
		$finish;
	end
endmodule

/* regular_polygon_vertex_generator_unit.f */
rtl/core/rpvg_pkg.sv
rtl/core/rpvg_front.sv
rtl/core/rpvg_back.sv
rtl/core/regular_polygon_vertex_generator_unit.sv
test/rpvg_vertex_checker.sv
test/regular_polygon_vertex_generator_unit_tb.sv
